/* rtl/sida_pkg.sv */
// Shared types, constants and helpers for the signed integer to decimal ASCII block.
// No dependencies; imported by the back end and the top level.
package sida_pkg;

   localparam logic [7:0] DIGIT_BASE    = 8'd48;   // '0'
   localparam logic [7:0] MINUS_CHAR    = 8'd45;   // '-'
   localparam logic [7:0] DIGIT_MAX     = 8'd57;   // '9'
   localparam int         BITS_PER_STEP = 4;       // binary bits folded into BCD per cycle

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } rsp_char_type;

   // Decimal digits needed for any unsigned value of the given width:
   // floor(bits * log10(2)) + 1, with log10(2) ~ 1233 / 4096.
   function automatic int digits_for_bits(input int bits);
      return ((bits * 1233) >> 12) + 1;
   endfunction

   // Double-dabble correction of one BCD digit before a shift.
   function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
      return (d >= 4'd5) ? (d + 4'd3) : d;
   endfunction

endpackage

/* rtl/sida_front.sv */
// Front end: accepts input transactions and splits them into sign and magnitude.
// Feeds the decoupling queue; no package dependencies.
module sida_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  req_push,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  req_full,
   input  logic                  q_full,
   output logic                  q_push,
   output logic [VALUE_BITS:0]   q_data
);

   logic                  negative;
   logic [VALUE_BITS-1:0] magnitude;

   always_comb begin
      negative  = req_value[VALUE_BITS-1];
      // the most negative value wraps to its own bit pattern, which is the right magnitude
      magnitude = negative ? (~req_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : req_value;
   end

   assign req_full = q_full;
   assign q_push   = req_push && !q_full;
   assign q_data   = {negative, magnitude};

endmodule

/* rtl/sida_queue.sv */
// Two-entry queue between the front end and the back end.
// Generic width; no package dependencies.
module sida_queue #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* rtl/sida_back.sv */
// Back end: double-dabble binary to BCD converter, digit emitter and output register.
// Depends on sida_pkg (constants, bcd_adjust, rsp_char_type).
module sida_back
   import sida_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  logic [VALUE_BITS:0] q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   output rsp_char_type        rsp_data,
   input  logic                rsp_pop
);

   localparam int ND    = digits_for_bits(VALUE_BITS);
   localparam int IW    = $clog2(ND);
   localparam int STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PW    = STEPS * BITS_PER_STEP;
   localparam int CW    = $clog2(STEPS + 1);
   localparam int BW    = ND * 4;

   // converter
   logic          cv_busy_ff;
   logic          cv_done_ff;
   logic          cv_neg_ff;
   logic [PW-1:0] cv_mag_ff;
   logic [BW-1:0] cv_bcd_ff;
   logic [CW-1:0] cv_cnt_ff;
   logic [PW-1:0] cv_mag_in;
   logic [BW-1:0] cv_bcd_in;
   logic [IW-1:0] lead_idx;

   // emitter
   logic          em_busy_ff;
   logic          em_neg_ff;
   logic [BW-1:0] em_dig_ff;
   logic [IW-1:0] em_idx_ff;
   logic          handoff;
   logic          out_load;
   rsp_char_type  next_char;
   logic [3:0]    cur_digit;

   // output register
   logic          out_valid_ff;
   rsp_char_type  out_ff;

   // four dependent correct-and-shift steps per cycle
   always_comb begin
      cv_bcd_in = cv_bcd_ff;
      cv_mag_in = cv_mag_ff;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         for (int d = 0; d < ND; d++) begin
            cv_bcd_in[d*4 +: 4] = bcd_adjust(cv_bcd_in[d*4 +: 4]);
         end
         cv_bcd_in = {cv_bcd_in[BW-2:0], cv_mag_in[PW-1]};
         cv_mag_in = {cv_mag_in[PW-2:0], 1'b0};
      end
   end

   // most significant nonzero digit; zero prints a single digit
   always_comb begin
      lead_idx = '0;
      for (int d = 0; d < ND; d++) begin
         if (cv_bcd_ff[d*4 +: 4] != 4'd0) begin
            lead_idx = IW'(d);
         end
      end
   end

   assign q_pop   = q_valid && !cv_busy_ff && !cv_done_ff;
   assign handoff = cv_done_ff && !em_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_busy_ff <= 1'b0;
         cv_done_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cv_busy_ff <= 1'b1;
         end else if (cv_busy_ff && (cv_cnt_ff == CW'(1))) begin
            cv_busy_ff <= 1'b0;
            cv_done_ff <= 1'b1;
         end else if (handoff) begin
            cv_done_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cv_neg_ff <= q_data[VALUE_BITS];
         cv_mag_ff <= PW'(q_data[VALUE_BITS-1:0]);
         cv_bcd_ff <= '0;
         cv_cnt_ff <= CW'(STEPS);
      end else if (cv_busy_ff) begin
         cv_mag_ff <= cv_mag_in;
         cv_bcd_ff <= cv_bcd_in;
         cv_cnt_ff <= cv_cnt_ff - CW'(1);
      end
   end

   assign cur_digit = em_dig_ff[em_idx_ff*4 +: 4];
   assign out_load  = em_busy_ff && (!out_valid_ff || rsp_pop);

   always_comb begin
      if (em_neg_ff) begin
         next_char.character = MINUS_CHAR;
         next_char.last      = 1'b0;
      end else begin
         next_char.character = DIGIT_BASE + {4'd0, cur_digit};
         next_char.last      = (em_idx_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_busy_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (handoff) begin
            em_busy_ff <= 1'b1;
         end else if (out_load && !em_neg_ff && (em_idx_ff == '0)) begin
            em_busy_ff <= 1'b0;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (handoff) begin
         em_neg_ff <= cv_neg_ff;
         em_dig_ff <= cv_bcd_ff;
         em_idx_ff <= lead_idx;
      end else if (out_load) begin
         if (em_neg_ff) begin
            em_neg_ff <= 1'b0;
         end else if (em_idx_ff != '0) begin
            em_idx_ff <= em_idx_ff - IW'(1);
         end
      end
      if (out_load) begin
         out_ff <= next_char;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Signed integer to decimal ASCII converter, top level.
// Depends on sida_pkg, sida_front, sida_queue and sida_back.
//
// Usage:
//   Input side is a queue: drive req_value and raise req_push; the transaction
//   is taken on a clock edge where req_full is low. Each value is a two's
//   complement integer of VALUE_BITS bits.
//   Result side is a queue: while rsp_empty is low, rsp_character holds the
//   oldest character and rsp_last flags the final character of a number.
//   Raise rsp_pop to take it. Characters come most significant first, with a
//   leading '-' for negative values; zero gives a single '0'.
// Timing:
//   Digits are formed by a double-dabble unit that folds 4 bits per cycle. The
//   converter works on the next value while the emitter drains the current
//   one; the emitter idles between numbers, and the one-character result
//   port sets the rate for long numbers.
// Reset clears all queues; no state carries between numbers. When the
//   receiver stalls, the result holds and the 2-entry input queue fills,
//   then req_full rises.
module signed_int_to_decimal_ascii
   import sida_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  req_full,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [7:0]            rsp_character,
   output logic                  rsp_last
);

   logic                q_full;
   logic                q_push;
   logic [VALUE_BITS:0] q_wdata;
   logic                q_valid;
   logic                q_pop;
   logic [VALUE_BITS:0] q_rdata;
   logic                rsp_valid;
   rsp_char_type        rsp_data;

   sida_front #(
      .VALUE_BITS(VALUE_BITS)
   ) u_front (
      .req_push (req_push),
      .req_value(req_value),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wdata)
   );

   sida_queue #(
      .WIDTH(VALUE_BITS + 1)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wdata),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_data (q_rdata)
   );

   sida_back #(
      .VALUE_BITS(VALUE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_rdata),
      .q_pop    (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .rsp_pop  (rsp_pop)
   );

   assign rsp_empty     = !rsp_valid;
   assign rsp_character = rsp_data.character;
   assign rsp_last      = rsp_data.last;

`ifndef ASSERT_OFF
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_character == MINUS_CHAR) ||
                      ((rsp_character >= DIGIT_BASE) && (rsp_character <= DIGIT_MAX))))
      else $error("illegal character on result port");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_character == MINUS_CHAR)) |-> !rsp_last)
      else $error("minus sign flagged as last character");
`endif

endmodule
